FILE: design/cda_pkg.sv
package cda_pkg;

   localparam int COUNT_WIDTH = 16;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 16;

   localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
   localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
   localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd2000;
   localparam logic               LEAP_RESET  = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 16'hFFFF;

   // y is a multiple of 25 exactly when (y * 25^-1 mod 2^16) <= floor((2^16-1)/25)
   localparam logic [YEAR_W-1:0] INV25       = 16'd23593;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

   typedef enum logic {
      OP_SET     = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: design/cda_leap.sv
module cda_leap (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [cda_pkg::YEAR_W-1:0] year,
   output logic                       leap
);

   logic [cda_pkg::YEAR_W-1:0] prod;
   logic                       div4;
   logic                       div16;
   logic                       div25;
   logic                       leap_ff;
   logic                       leap_in;

   // low half of the product only: modular inverse test for divisibility by 25
   assign prod  = cda_pkg::YEAR_W'(year * cda_pkg::INV25);
   assign div25 = (prod <= cda_pkg::DIV25_LIMIT);
   assign div4  = (year[1:0] == 2'd0);
   assign div16 = (year[3:0] == 4'd0);

   // leap: div by 4 and not by 100, or div by 400
   assign leap_in = div4 && (!div25 || div16);

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_ff <= cda_pkg::LEAP_RESET;
      end else begin
         leap_ff <= leap_in;
      end
   end

   assign leap = leap_ff;

endmodule

FILE: design/calendar_date_advance.sv
// set request: after acceptance, waits in the leap state, clamps the day, then result valid
// advance request: result valid once the day count is used up or the year limit is hit,
// one day per cycle through the day stepper, pausing in the leap state at each new year
// for the leap-year unit; one request at a time, next accepted after result taken
// synchronous reset sets the date to 1 Jan 2000
module calendar_date_advance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // op
   input  logic [47:0] req_tdata,   // new_day[7:0], new_month[15:8], new_year[31:16],
                                    // day_count[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // day[4:0], month[8:5], year[24:9], overflowed[25],
                                    // zero pad[31:26]
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LEAP  = 5'b00010,
      ST_CLAMP = 5'b00100,
      ST_STEP  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [cda_pkg::DAY_W-1:0]       day_ff, day_in;
   logic [cda_pkg::MONTH_W-1:0]     month_ff, month_in;
   logic [cda_pkg::YEAR_W-1:0]      year_ff, year_in;
   logic [cda_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic signed [7:0]               nday_ff, nday_in;
   logic                            op_ff, op_in;
   logic                            flag_ff, flag_in;

   logic                            leap;
   logic                            req_fire;
   logic signed [7:0]               req_day;
   logic signed [7:0]               req_month;
   logic [cda_pkg::MONTH_W-1:0]     month_clamped;
   logic [cda_pkg::DAY_W-1:0]       month_len;
   logic signed [7:0]               max_day_s;

   assign req_day   = $signed(req_tdata[7:0]);
   assign req_month = $signed(req_tdata[15:8]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // leap flag of year_ff, registered: it follows a change of year_ff in the next cycle
   cda_leap u_leap (
      .clock (clock),
      .reset (reset),
      .year  (year_ff),
      .leap  (leap)
   );

   always_comb begin
      if (req_month < 8'sd1) begin
         month_clamped = cda_pkg::MONTH_FIRST;
      end else if (req_month > 8'sd12) begin
         month_clamped = cda_pkg::MONTH_LAST;
      end else begin
         month_clamped = req_month[cda_pkg::MONTH_W-1:0];
      end
   end

   assign month_len = cda_pkg::month_days(month_ff, leap);
   assign max_day_s = $signed({3'b000, month_len});

   always_comb begin
      state_in = state_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      count_in = count_ff;
      nday_in  = nday_ff;
      op_in    = op_ff;
      flag_in  = flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               flag_in  = 1'b0;
               op_in    = req_tuser;
               count_in = req_tdata[32 +: cda_pkg::COUNT_WIDTH];
               if (req_tuser == cda_pkg::OP_SET) begin
                  month_in = month_clamped;
                  year_in  = req_tdata[31:16];
                  nday_in  = req_day;
                  state_in = ST_LEAP;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_LEAP: begin
            state_in = (op_ff == cda_pkg::OP_SET) ? ST_CLAMP : ST_STEP;
         end
         ST_CLAMP: begin
            if (nday_ff > max_day_s) begin
               day_in = month_len;
            end else if (nday_ff < 8'sd1) begin
               day_in = cda_pkg::DAY_FIRST;
            end else begin
               day_in = nday_ff[cda_pkg::DAY_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_STEP: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else if (day_ff >= month_len) begin
               if (month_ff >= cda_pkg::MONTH_LAST) begin
                  if (year_ff == cda_pkg::YEAR_MAX) begin
                     flag_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     day_in   = cda_pkg::DAY_FIRST;
                     month_in = cda_pkg::MONTH_FIRST;
                     year_in  = year_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                     // wait for the leap flag of the new year
                     state_in = ST_LEAP;
                  end
               end else begin
                  day_in   = cda_pkg::DAY_FIRST;
                  month_in = month_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               day_in   = day_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         day_ff   <= cda_pkg::DAY_RESET;
         month_ff <= cda_pkg::MONTH_RESET;
         year_ff  <= cda_pkg::YEAR_RESET;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      nday_ff  <= nday_in;
      op_ff    <= op_in;
   end

   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {6'd0, flag_ff, year_ff, month_ff, day_ff};

endmodule

FILE: test/calendar_date_advance_tb.sv
module calendar_date_advance_tb;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_LIMIT = 300000;
   localparam int MONTH_TABLE [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [cda_pkg::DAY_W-1:0]   day;
      logic [cda_pkg::MONTH_W-1:0] month;
      logic [cda_pkg::YEAR_W-1:0]  year;
      logic                        overflowed;
   } date_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;   // op
   logic [47:0] req_tdata = '0;     // new_day[7:0], new_month[15:8], new_year[31:16],
                                    // day_count[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // day[4:0], month[8:5], year[24:9], overflowed[25]

   // predicted calendar state
   logic [cda_pkg::DAY_W-1:0]   cal_day;
   logic [cda_pkg::MONTH_W-1:0] cal_month;
   logic [cda_pkg::YEAR_W-1:0]  cal_year;

   date_result_type expected_dates[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int set_count      = 0;
   int advance_count  = 0;
   int limit_hits     = 0;
   int days_stepped   = 0;

   calendar_date_advance DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic bit leap_year(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int month_length(input int mo, input int yr);
      if (mo < 1 || mo > 12) return 31;
      if (mo == 2 && leap_year(yr)) return 29;
      return MONTH_TABLE[mo];
   endfunction

   function automatic void predict_date(input cda_pkg::op_type op, input logic [7:0] d,
                                        input logic [7:0] m, input logic [15:0] y,
                                        input logic [15:0] cnt);
      date_result_type r;
      int dd;
      int mm;
      int lim;
      int k;
      r.overflowed = 1'b0;
      if (op == cda_pkg::OP_SET) begin
         dd = $signed(d);
         mm = $signed(m);
         if (mm < 1) mm = 1;
         else if (mm > 12) mm = 12;
         lim = month_length(mm, y);
         if (dd > lim) dd = lim;
         else if (dd < 1) dd = 1;
         cal_year  = y;
         cal_month = mm[cda_pkg::MONTH_W-1:0];
         cal_day   = dd[cda_pkg::DAY_W-1:0];
         set_count++;
      end else begin
         advance_count++;
         for (k = 0; k < int'(cnt); k++) begin
            if (int'(cal_day) + 1 > month_length(cal_month, cal_year)) begin
               if (cal_month >= 4'd12) begin
                  if (cal_year == 16'hFFFF) begin
                     r.overflowed = 1'b1;
                     break;
                  end
                  cal_day   = 5'd1;
                  cal_month = 4'd1;
                  cal_year  = cal_year + 16'd1;
               end else begin
                  cal_day   = 5'd1;
                  cal_month = cal_month + 4'd1;
               end
            end else begin
               cal_day = cal_day + 5'd1;
            end
            days_stepped++;
         end
         if (r.overflowed) limit_hits++;
      end
      r.day   = cal_day;
      r.month = cal_month;
      r.year  = cal_year;
      expected_dates.push_back(r);
   endfunction

   task automatic send_request(input cda_pkg::op_type op, input logic [7:0] d,
                               input logic [7:0] m, input logic [15:0] y,
                               input logic [15:0] cnt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {cnt, y, m, d};
      do @(posedge clock); while (!req_tready);
      predict_date(op, d, m, y, cnt);
   endtask

   task automatic set_date(input int d, input int m, input int y);
      send_request(cda_pkg::OP_SET, d[7:0], m[7:0], y[15:0], 16'($urandom));
   endtask

   task automatic advance_days(input int n);
      send_request(cda_pkg::OP_ADVANCE, 8'($urandom), 8'($urandom), 16'($urandom), n[15:0]);
   endtask

   always @(posedge clock) begin
      date_result_type want;
      date_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.day        = rsp_tdata[4:0];
         got.month      = rsp_tdata[8:5];
         got.year       = rsp_tdata[24:9];
         got.overflowed = rsp_tdata[25];
         if (expected_dates.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result %0d/%0d/%0d ovf=%0b", got.day, got.month,
                        got.year, got.overflowed);
            mismatch_count++;
         end else begin
            want = expected_dates.pop_front();
            if (got.day != want.day || got.month != want.month || got.year != want.year ||
                got.overflowed != want.overflowed) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected %0d/%0d/%0d ovf=%0b, got %0d/%0d/%0d ovf=%0b",
                           want.day, want.month, want.year, want.overflowed,
                           got.day, got.month, got.year, got.overflowed);
               mismatch_count++;
            end
         end
      end
   end

   // date right after reset via a zero-length advance, then a one-day advance
   task automatic check_reset_date();
      advance_days(0);
      advance_days(1);
   endtask

   task automatic check_set_clamping();
      set_date(-128, -128, 0);
      set_date(127, 127, 65535);
      set_date(0, 0, 1999);
      set_date(30, 13, 2010);
      set_date(31, 4, 2015);
      set_date(29, 2, 1900);
      set_date(29, 2, 2000);
      set_date(29, 2, 2023);
      set_date(29, 2, 2024);
   endtask

   task automatic check_rollover_and_leap();
      set_date(31, 1, 2000);
      advance_days(1);
      set_date(28, 2, 2100);
      advance_days(1);
      set_date(31, 12, 1999);
      advance_days(1);
      advance_days(0);
   endtask

   // running off the end of the last year holds the date and flags that request only
   task automatic check_year_limit();
      set_date(31, 12, 65535);
      advance_days(1);
      advance_days(0);
      set_date(20, 12, 65535);
      advance_days(11);
      set_date(1, 1, 65500);
      advance_days(65535);
   endtask

   task automatic check_long_advance();
      set_date(1, 1, 2000);
      advance_days(65535);
   endtask

   task automatic check_random_traffic(input int count);
      int i;
      int r;
      int d;
      int m;
      int y;
      int n;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35) begin
            if ($urandom_range(99) < 70) begin
               d = $urandom_range(31, 1);
               m = $urandom_range(12, 1);
            end else begin
               d = $urandom_range(255);
               m = $urandom_range(255);
            end
            r = $urandom_range(99);
            if (r < 20) begin
               y = $urandom_range(65535, 65530);
               if ($urandom_range(1)) m = 12;
            end else if (r < 60) begin
               y = $urandom_range(2100, 1890);
            end else begin
               y = $urandom_range(65535);
            end
            set_date(d, m, y);
         end else begin
            r = $urandom_range(99);
            if (r < 60) n = $urandom_range(40);
            else if (r < 90) n = $urandom_range(800);
            else if (r < 98) n = $urandom_range(4000);
            else n = $urandom_range(65535, 20000);
            advance_days(n);
         end
      end
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int drain;
      cal_day   = cda_pkg::DAY_RESET;
      cal_month = cda_pkg::MONTH_RESET;
      cal_year  = cda_pkg::YEAR_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_reset_date();
      check_set_clamping();
      check_rollover_and_leap();
      check_year_limit();
      check_long_advance();

      send_idle_pct = 0;  recv_stall_pct = 0;
      check_random_traffic(18);
      send_idle_pct = 50; recv_stall_pct = 0;
      check_random_traffic(18);
      send_idle_pct = 0;  recv_stall_pct = 50;
      check_random_traffic(18);
      send_idle_pct = 16; recv_stall_pct = 16;
      check_random_traffic(18);

      @(negedge clock);
      req_tvalid <= 1'b0;

      drain = 0;
      while (expected_dates.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (expected_dates.size() != 0) begin
         $display("%0d results never arrived", expected_dates.size());
         mismatch_count += expected_dates.size();
      end

      $display("summary: %0d set and %0d advance requests, %0d days stepped",
               set_count, advance_count, days_stepped);
      $display("summary: %0d advances ran into the year limit, %0d mismatches",
               limit_hits, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
design/cda_pkg.sv
design/cda_leap.sv
design/calendar_date_advance.sv
test/calendar_date_advance_tb.sv
